### rtl/assert_macros.svh
// Assertion helpers used by the port checker gocl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define GOCL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gocl assertion failed");

// Expression must never be true outside reset.
`define GOCL_NEVER(lbl, clk, rst_n, expr) \
	`GOCL_ASSERT(lbl, clk, rst_n, !(expr))

`endif

### rtl/gocl_pkg.sv
// ----------------------------------------------------------------------------
// gocl_pkg
// Types, constants and codes of the occupancy-grid component labeler.
// ----------------------------------------------------------------------------
`default_nettype none
package gocl_pkg;

	localparam int GRID_DEF   = 128;
	localparam int ROI_W      = 16;
	localparam int THR_W      = 4;
	localparam int COUNT_W    = 4;
	localparam int LABEL_W    = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [COUNT_W-1:0]    COUNT_MAX = 4'd15;
	localparam logic [LABEL_W-1:0]    LABEL_MAX = 14'd16383;
	localparam logic [ROI_W-1:0]      ROI_RESET = 16'd5000;
	localparam logic [THR_W-1:0]      THR_RESET = 4'd2;
	localparam logic [CFG_IDX_W-1:0]  CFG_ROI   = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  CFG_THR   = 1'b1;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_LABEL = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [7:0]         cell_x;
		logic [7:0]         cell_y;
	} in_t;

	typedef struct packed {
		logic               accepted;
		logic [LABEL_W-1:0] label;
		logic [LABEL_W-1:0] cluster_count;
	} out_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_DIV, OP_CNT_RD, OP_CNT_WR, OP_LBL_RD, OP_CLR,
		OP_BLD_RD, OP_BLD_CHK, OP_BLD_WR, OP_SCAN_RD, OP_SCAN_CHK, OP_POP,
		OP_POP_LD, OP_NB_RD, OP_NB_CHK, OP_FINISH, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last_cell;
		logic nb_last;
		logic sp_zero;
		logic hit;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

### rtl/gocl_ctrl.sv
// ----------------------------------------------------------------------------
// gocl_ctrl
// Sequencer: steps the datapath through add, label, read and clear requests.
// ----------------------------------------------------------------------------
`default_nettype none
module gocl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  gocl_pkg::action_t     in_act,
	input  wire logic             out_stall,
	input  gocl_pkg::sts_t        sts,
	output gocl_pkg::cmd_t        cmd,
	output logic                  in_stall,
	output logic                  out_valid
);

	typedef enum logic [17:0] {
		S_CLR_RST  = 18'b000000000000000001,
		S_IDLE     = 18'b000000000000000010,
		S_DIV      = 18'b000000000000000100,
		S_CNT_RD   = 18'b000000000000001000,
		S_CNT_WR   = 18'b000000000000010000,
		S_RD       = 18'b000000000000100000,
		S_CLR      = 18'b000000000001000000,
		S_BLD_RD   = 18'b000000000010000000,
		S_BLD_CHK  = 18'b000000000100000000,
		S_BLD_WR   = 18'b000000001000000000,
		S_SCAN_RD  = 18'b000000010000000000,
		S_SCAN_CHK = 18'b000000100000000000,
		S_POP      = 18'b000001000000000000,
		S_POP_LD   = 18'b000010000000000000,
		S_NB_RD    = 18'b000100000000000000,
		S_NB_CHK   = 18'b001000000000000000,
		S_FINISH   = 18'b010000000000000000,
		S_DONE     = 18'b100000000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   emit;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	// load the result register once the previous result has gone
	assign emit      = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		cmd.op  = gocl_pkg::OP_NONE;
		case (state_q)
			S_CLR_RST: begin
				cmd.op = gocl_pkg::OP_CLR;
				if (sts.last_cell) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.op = gocl_pkg::OP_CAPTURE;
					case (in_act)
						gocl_pkg::ACT_ADD:   state_d = S_DIV;
						gocl_pkg::ACT_LABEL: state_d = S_BLD_RD;
						gocl_pkg::ACT_READ:  state_d = S_RD;
						default:             state_d = S_CLR;
					endcase
				end
			end
			S_DIV: begin
				cmd.op = gocl_pkg::OP_DIV;
				if (sts.div_last) state_d = S_CNT_RD;
			end
			S_CNT_RD: begin
				cmd.op  = gocl_pkg::OP_CNT_RD;
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.op  = gocl_pkg::OP_CNT_WR;
				state_d = S_DONE;
			end
			S_RD: begin
				cmd.op  = gocl_pkg::OP_LBL_RD;
				state_d = S_DONE;
			end
			S_CLR: begin
				cmd.op = gocl_pkg::OP_CLR;
				if (sts.last_cell) state_d = S_DONE;
			end
			S_BLD_RD: begin
				cmd.op  = gocl_pkg::OP_BLD_RD;
				state_d = S_BLD_CHK;
			end
			S_BLD_CHK: begin
				cmd.op  = gocl_pkg::OP_BLD_CHK;
				state_d = sts.nb_last ? S_BLD_WR : S_BLD_RD;
			end
			S_BLD_WR: begin
				cmd.op  = gocl_pkg::OP_BLD_WR;
				state_d = sts.last_cell ? S_SCAN_RD : S_BLD_RD;
			end
			S_SCAN_RD: begin
				cmd.op  = gocl_pkg::OP_SCAN_RD;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd.op = gocl_pkg::OP_SCAN_CHK;
				if (sts.hit)            state_d = S_POP;
				else if (sts.last_cell) state_d = S_FINISH;
				else                    state_d = S_SCAN_RD;
			end
			S_POP: begin
				cmd.op = gocl_pkg::OP_POP;
				if (!sts.sp_zero)       state_d = S_POP_LD;
				else if (sts.last_cell) state_d = S_FINISH;
				else                    state_d = S_SCAN_RD;
			end
			S_POP_LD: begin
				cmd.op  = gocl_pkg::OP_POP_LD;
				state_d = S_NB_RD;
			end
			S_NB_RD: begin
				cmd.op  = gocl_pkg::OP_NB_RD;
				state_d = S_NB_CHK;
			end
			S_NB_CHK: begin
				cmd.op  = gocl_pkg::OP_NB_CHK;
				state_d = sts.nb_last ? S_POP : S_NB_RD;
			end
			S_FINISH: begin
				cmd.op  = gocl_pkg::OP_FINISH;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (emit) begin
					cmd.op  = gocl_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR_RST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/gocl_datapath.sv
// ----------------------------------------------------------------------------
// gocl_datapath
// Grid memories, binning divider, cell and neighbour walkers, flood stack.
// ----------------------------------------------------------------------------
`default_nettype none
module gocl_datapath #(
	parameter int GRID = gocl_pkg::GRID_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  gocl_pkg::cmd_t                        cmd,
	input  gocl_pkg::in_t                         in_data,
	input  wire logic [gocl_pkg::ROI_W-1:0]       roi,
	input  wire logic [gocl_pkg::THR_W-1:0]       thr,
	output gocl_pkg::sts_t                        sts,
	output gocl_pkg::out_t                        out_data
);

	localparam int CW     = $clog2(GRID);
	localparam int NCELLS = GRID * GRID;
	localparam int AW     = $clog2(NCELLS);
	localparam int SW     = gocl_pkg::ROI_W + 1;
	localparam int NW     = SW + CW;
	localparam int KW     = $clog2(CW);
	localparam int LW     = gocl_pkg::LABEL_W;
	localparam int CNTW   = gocl_pkg::COUNT_W;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		cell_addr = AW'(AW'(x) * AW'(GRID) + AW'(y));
	endfunction

	// memories
	logic [CNTW-1:0] cnt_mem [NCELLS];
	logic [LW-1:0]   lbl_mem [NCELLS];
	logic            occ_mem [NCELLS];
	logic [2*CW-1:0] stk_mem [NCELLS];

	logic            cnt_we, cnt_re, lbl_we, lbl_re, occ_we, occ_re, stk_we, stk_re;
	logic [AW-1:0]   cnt_wa, cnt_ra, lbl_wa, lbl_ra, occ_wa, occ_ra, stk_wa, stk_ra;
	logic [CNTW-1:0] cnt_wd, cnt_rd_q;
	logic [LW-1:0]   lbl_wd, lbl_rd_q;
	logic            occ_wd, occ_rd_q;
	logic [2*CW-1:0] stk_wd, stk_rd_q;

	// request capture and divider
	gocl_pkg::action_t act_q;
	logic              inside_q, rng_q;
	logic [CW-1:0]     rx_q, ry_q, qx_q, qy_q;
	logic [NW-1:0]     numx_q, numy_q;
	logic [SW-1:0]     span_q;
	logic [KW-1:0]     k_q;

	// walkers and labeling state
	logic [CW-1:0]   cx_q, cy_q, fx_q, fy_q;
	logic [1:0]      ndx_q, ndy_q;
	logic [AW:0]     sp_q;
	logic [LW-1:0]   next_q, total_q, nxt_inc;
	logic            acc_q, nbv_q;

	logic signed [18:0] sx_w, sy_w;
	logic [17:0]        span_w;
	logic               inx_w, iny_w, rng_w;
	logic [NW-1:0]      dsh, numx_w, numy_w;
	logic               gex, gey;
	logic               last_cell, nb_last, flood, nb_ok;
	logic [CW-1:0]      bx, by, nbx, nby;
	logic [CW:0]        tx, ty, txm, tym;
	logic [AW-1:0]      cur_a, nb_a, bin_a;
	gocl_pkg::op_t      op;

	assign op = cmd.op;

	assign sx_w   = $signed({{2{in_data.point_x[15]}}, in_data.point_x, 1'b0})
	              + $signed({3'b000, roi});
	assign sy_w   = $signed({{2{in_data.point_y[15]}}, in_data.point_y, 1'b0})
	              + $signed({3'b000, roi});
	assign span_w = {1'b0, roi, 1'b0};
	assign inx_w  = !sx_w[18] && (sx_w[17:0] < span_w);
	assign iny_w  = !sy_w[18] && (sy_w[17:0] < span_w);
	assign numx_w = NW'(NW'(sx_w[SW-1:0]) * NW'(GRID));
	assign numy_w = NW'(NW'(sy_w[SW-1:0]) * NW'(GRID));
	assign rng_w  = (9'(in_data.cell_x) < 9'(GRID)) && (9'(in_data.cell_y) < 9'(GRID));

	assign dsh = NW'(span_q) << k_q;
	assign gex = numx_q >= dsh;
	assign gey = numy_q >= dsh;

	assign flood = (op == gocl_pkg::OP_NB_RD) || (op == gocl_pkg::OP_NB_CHK);
	assign bx    = flood ? fx_q : cx_q;
	assign by    = flood ? fy_q : cy_q;
	assign tx    = {1'b0, bx} + {{(CW-1){1'b0}}, ndx_q};
	assign ty    = {1'b0, by} + {{(CW-1){1'b0}}, ndy_q};
	assign txm   = tx - (CW+1)'(1);
	assign tym   = ty - (CW+1)'(1);
	assign nbx   = txm[CW-1:0];
	assign nby   = tym[CW-1:0];
	assign nb_ok = (tx != '0) && (ty != '0) && (tx <= (CW+1)'(GRID)) && (ty <= (CW+1)'(GRID));

	assign cur_a = cell_addr(cx_q, cy_q);
	assign nb_a  = cell_addr(nbx, nby);
	assign bin_a = cell_addr(qx_q, qy_q);

	assign last_cell = (cx_q == CW'(GRID-1)) && (cy_q == CW'(GRID-1));
	assign nb_last   = (ndx_q == 2'd2) && (ndy_q == 2'd2);
	assign nxt_inc   = (next_q == gocl_pkg::LABEL_MAX) ? next_q : next_q + LW'(1);

	assign sts.last_cell = last_cell;
	assign sts.nb_last   = nb_last;
	assign sts.sp_zero   = (sp_q == '0);
	assign sts.hit       = occ_rd_q;
	assign sts.div_last  = (k_q == '0);

	always_comb begin
		cnt_we = 1'b0; cnt_wa = cur_a; cnt_wd = '0; cnt_re = 1'b0; cnt_ra = nb_a;
		lbl_we = 1'b0; lbl_wa = cur_a; lbl_wd = '0; lbl_re = 1'b0;
		lbl_ra = cell_addr(rx_q, ry_q);
		occ_we = 1'b0; occ_wa = cur_a; occ_wd = 1'b0; occ_re = 1'b0; occ_ra = cur_a;
		stk_we = 1'b0; stk_wa = sp_q[AW-1:0]; stk_wd = {nbx, nby};
		stk_re = 1'b0; stk_ra = AW'(sp_q - (AW+1)'(1));
		case (op)
			gocl_pkg::OP_CLR: begin
				cnt_we = 1'b1;
				lbl_we = 1'b1;
			end
			gocl_pkg::OP_CNT_RD: begin
				cnt_re = 1'b1;
				cnt_ra = bin_a;
			end
			gocl_pkg::OP_CNT_WR: begin
				cnt_we = inside_q;
				cnt_wa = bin_a;
				cnt_wd = (cnt_rd_q == gocl_pkg::COUNT_MAX) ? cnt_rd_q : cnt_rd_q + CNTW'(1);
			end
			gocl_pkg::OP_LBL_RD: lbl_re = rng_q;
			gocl_pkg::OP_BLD_RD: cnt_re = nb_ok;
			gocl_pkg::OP_BLD_WR: begin
				occ_we = 1'b1;
				occ_wd = acc_q;
				lbl_we = 1'b1;
			end
			gocl_pkg::OP_SCAN_RD: occ_re = 1'b1;
			gocl_pkg::OP_SCAN_CHK: begin
				occ_we = occ_rd_q;
				lbl_we = occ_rd_q;
				lbl_wd = nxt_inc;
				stk_we = occ_rd_q;
				stk_wa = '0;
				stk_wd = {cx_q, cy_q};
			end
			gocl_pkg::OP_POP: stk_re = (sp_q != '0);
			gocl_pkg::OP_NB_RD: begin
				occ_re = nb_ok;
				occ_ra = nb_a;
			end
			gocl_pkg::OP_NB_CHK: begin
				occ_we = nbv_q && occ_rd_q;
				occ_wa = nb_a;
				lbl_we = nbv_q && occ_rd_q;
				lbl_wa = nb_a;
				lbl_wd = next_q;
				stk_we = nbv_q && occ_rd_q;
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
		if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
		if (lbl_re) lbl_rd_q <= lbl_mem[lbl_ra];
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		if (occ_re) occ_rd_q <= occ_mem[occ_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
	end

	// payload: capture, divider, neighbour flag, flood position, output
	always_ff @(posedge clk) begin
		case (op)
			gocl_pkg::OP_CAPTURE: begin
				act_q    <= in_data.action;
				inside_q <= inx_w && iny_w;
				rng_q    <= rng_w;
				rx_q     <= in_data.cell_x[CW-1:0];
				ry_q     <= in_data.cell_y[CW-1:0];
				numx_q   <= numx_w;
				numy_q   <= numy_w;
				span_q   <= span_w[SW-1:0];
				qx_q     <= '0;
				qy_q     <= '0;
			end
			gocl_pkg::OP_DIV: begin
				if (gex) begin
					numx_q     <= numx_q - dsh;
					qx_q[k_q]  <= 1'b1;
				end
				if (gey) begin
					numy_q     <= numy_q - dsh;
					qy_q[k_q]  <= 1'b1;
				end
			end
			gocl_pkg::OP_BLD_RD, gocl_pkg::OP_NB_RD: nbv_q <= nb_ok;
			gocl_pkg::OP_POP_LD: begin
				fx_q <= stk_rd_q[2*CW-1:CW];
				fy_q <= stk_rd_q[CW-1:0];
			end
			gocl_pkg::OP_OUT: begin
				out_data.accepted      <= (act_q == gocl_pkg::ACT_ADD) && inside_q;
				out_data.label         <= ((act_q == gocl_pkg::ACT_READ) && rng_q) ? lbl_rd_q : '0;
				out_data.cluster_count <= total_q;
			end
			default: ;
		endcase
	end

	// control: walkers, stack pointer, label counter, total, divider step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			ndx_q   <= '0;
			ndy_q   <= '0;
			sp_q    <= '0;
			next_q  <= '0;
			total_q <= '0;
			acc_q   <= 1'b0;
			k_q     <= KW'(CW-1);
		end else begin
			case (op)
				gocl_pkg::OP_CAPTURE: begin
					next_q <= '0;
					k_q    <= KW'(CW-1);
				end
				gocl_pkg::OP_DIV: if (k_q != '0) k_q <= k_q - KW'(1);
				gocl_pkg::OP_BLD_CHK, gocl_pkg::OP_NB_CHK: begin
					if (op == gocl_pkg::OP_BLD_CHK && nbv_q && cnt_rd_q > thr) acc_q <= 1'b1;
					if (op == gocl_pkg::OP_NB_CHK && nbv_q && occ_rd_q) sp_q <= sp_q + (AW+1)'(1);
					if (ndy_q == 2'd2) begin
						ndy_q <= '0;
						ndx_q <= nb_last ? 2'd0 : ndx_q + 2'd1;
					end else begin
						ndy_q <= ndy_q + 2'd1;
					end
				end
				gocl_pkg::OP_SCAN_CHK: begin
					if (occ_rd_q) begin
						next_q <= nxt_inc;
						sp_q   <= (AW+1)'(1);
					end
				end
				gocl_pkg::OP_POP: if (sp_q != '0) sp_q <= sp_q - (AW+1)'(1);
				gocl_pkg::OP_FINISH: total_q <= next_q;
				gocl_pkg::OP_CLR: total_q <= '0;
				default: ;
			endcase
			if (op == gocl_pkg::OP_BLD_WR) acc_q <= 1'b0;
			// step the cell walker
			if (op == gocl_pkg::OP_CLR || op == gocl_pkg::OP_BLD_WR
			    || (op == gocl_pkg::OP_SCAN_CHK && !occ_rd_q)
			    || (op == gocl_pkg::OP_POP && sp_q == '0)) begin
				if (cy_q == CW'(GRID-1)) begin
					cy_q <= '0;
					cx_q <= (cx_q == CW'(GRID-1)) ? '0 : cx_q + CW'(1);
				end else begin
					cy_q <= cy_q + CW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/grid_occupancy_component_labeler.sv
// ----------------------------------------------------------------------------
// grid_occupancy_component_labeler
// Bins points into an occupancy grid and labels 8-connected occupied regions.
// ----------------------------------------------------------------------------
// Add: capture, binning divider (one quotient bit a cycle), count read, count write.
// Read: one label memory read. Clear: one cell a cycle over both memories.
// Label: a build pass walks the 3x3 neighbourhood of every cell, reading and
//   checking each neighbour, then a scan floods each cluster via a stack.
// One request at a time; a waiting result holds only the last step. After reset
//   a clearing pass over every cell runs, requests stalled meanwhile.
`default_nettype none
module grid_occupancy_component_labeler #(
	parameter int GRID = gocl_pkg::GRID_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  gocl_pkg::in_t                            in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output gocl_pkg::out_t                           out_data,
	input  wire logic                                cfg_we,
	input  wire logic [gocl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [gocl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [gocl_pkg::ROI_W-1:0] roi_q;
	logic [gocl_pkg::THR_W-1:0] thr_q;
	gocl_pkg::cmd_t             cmd;
	gocl_pkg::sts_t             sts;

	// configuration registers; the user must write them only between requests, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q <= gocl_pkg::ROI_RESET;
			thr_q <= gocl_pkg::THR_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				gocl_pkg::CFG_ROI: roi_q <= cfg_data[gocl_pkg::ROI_W-1:0];
				gocl_pkg::CFG_THR: thr_q <= cfg_data[gocl_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: hold requests while busy
	gocl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_act    (in_data.action),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// memories, divider and walkers
	gocl_datapath #(.GRID(GRID)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.roi      (roi_q),
		.thr      (thr_q),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

### rtl/gocl_checker.sv
// ----------------------------------------------------------------------------
// gocl_checker
// Port-level checks of the labeler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gocl_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_stall,
	input gocl_pkg::in_t       in_data,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input gocl_pkg::out_t      out_data
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	`GOCL_ASSERT(a_busy_after_req, clk, arst_n, in_acc |=> in_stall)
	`GOCL_ASSERT(a_req_hold, clk, arst_n, in_valid && in_stall |=> in_valid && $stable(in_data))
	`GOCL_NEVER(a_add_no_label, clk, arst_n, out_valid && out_data.accepted && out_data.label != '0)
	`GOCL_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

endmodule

bind grid_occupancy_component_labeler gocl_checker u_gocl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

### dv/grid_label_checker.sv
// ----------------------------------------------------------------------------
// grid_label_checker
// Watches the request, reply and register ports of the labeler. Keeps its own
// occupancy grid, predicts each reply and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_label_checker
	import gocl_pkg::*;
#(
	parameter int GRID = GRID_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  in_t                        in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         pending,
	output int                         failures,
	output int                         points_binned,
	output int                         labelings,
	output int                         max_clusters
);

	localparam int NCELLS = GRID * GRID;

	logic [ROI_W-1:0]   roi;
	logic [THR_W-1:0]   thr;
	logic [COUNT_W-1:0] hits [NCELLS];
	logic [LABEL_W-1:0] cell_lbl [NCELLS];
	bit                 occupied [NCELLS];
	int                 walk [NCELLS];
	logic [LABEL_W-1:0] clusters;
	out_t               pending_replies [$];

	assign pending = pending_replies.size();

	function automatic int bin_of(logic signed [15:0] c);
		longint span, s;
		span = 2 * longint'(roi);
		s    = 2 * longint'(c) + longint'(roi);
		if (span == 0 || s < 0 || s >= span)
			return -1;
		return int'((longint'(GRID) * s) / span);
	endfunction

	// Seed occupancy from the 3x3 neighbourhood, then flood 8-connected groups
	function automatic void relabel();
		int sp, c, nx, ny, n;
		logic [LABEL_W-1:0] next;
		for (int i = 0; i < NCELLS; i++) begin
			occupied[i] = 0;
			cell_lbl[i] = '0;
		end
		for (int x = 0; x < GRID; x++)
			for (int y = 0; y < GRID; y++)
				if (hits[x*GRID+y] > COUNT_W'(thr))
					for (int dx = -1; dx <= 1; dx++)
						for (int dy = -1; dy <= 1; dy++) begin
							nx = x + dx;
							ny = y + dy;
							if (nx >= 0 && nx < GRID && ny >= 0 && ny < GRID)
								occupied[nx*GRID+ny] = 1;
						end
		next = '0;
		for (int i = 0; i < NCELLS; i++) begin
			if (!occupied[i])
				continue;
			if (next < LABEL_MAX)
				next++;
			occupied[i] = 0;
			cell_lbl[i] = next;
			sp = 0;
			walk[sp++] = i;
			while (sp > 0) begin
				c = walk[--sp];
				for (int dx = -1; dx <= 1; dx++)
					for (int dy = -1; dy <= 1; dy++) begin
						nx = c / GRID + dx;
						ny = c % GRID + dy;
						if (nx < 0 || nx >= GRID || ny < 0 || ny >= GRID)
							continue;
						n = nx * GRID + ny;
						if (!occupied[n])
							continue;
						occupied[n] = 0;
						cell_lbl[n] = next;
						walk[sp++] = n;
					end
			end
		end
		clusters = next;
		labelings++;
		if (int'(next) > max_clusters)
			max_clusters = int'(next);
	endfunction

	function automatic out_t predict_reply(in_t req);
		out_t r;
		int bx, by;
		r = '0;
		case (req.action)
			ACT_ADD: begin
				bx = bin_of(req.point_x);
				by = bin_of(req.point_y);
				if (bx >= 0 && by >= 0 && bx < GRID && by < GRID) begin
					if (hits[bx*GRID+by] < COUNT_MAX)
						hits[bx*GRID+by]++;
					r.accepted = 1'b1;
					points_binned++;
				end
			end
			ACT_LABEL: relabel();
			ACT_READ: begin
				if (req.cell_x < GRID && req.cell_y < GRID)
					r.label = cell_lbl[int'(req.cell_x)*GRID + int'(req.cell_y)];
			end
			default: begin
				for (int i = 0; i < NCELLS; i++) begin
					hits[i]     = '0;
					cell_lbl[i] = '0;
				end
				clusters = '0;
			end
		endcase
		r.cluster_count = clusters;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		failures++;
	endtask

	initial begin
		failures      = 0;
		points_binned = 0;
		labelings     = 0;
		max_clusters  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			roi      = ROI_RESET;
			thr      = THR_RESET;
			clusters = '0;
			for (int i = 0; i < NCELLS; i++) begin
				hits[i]     = '0;
				cell_lbl[i] = '0;
			end
			pending_replies.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_ROI)
					roi = cfg_data;
				else if (cfg_idx == CFG_THR)
					thr = cfg_data[THR_W-1:0];
			end
			if (in_valid && !in_stall)
				pending_replies.insert(pending_replies.size(), predict_reply(in_data));
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					report_mismatch("replies outstanding", 0, 1);
				end else begin
					want = pending_replies.pop_front();
					if (out_data.accepted !== want.accepted)
						report_mismatch("accepted", out_data.accepted, want.accepted);
					if (out_data.label !== want.label)
						report_mismatch("label", out_data.label, want.label);
					if (out_data.cluster_count !== want.cluster_count)
						report_mismatch("cluster_count", out_data.cluster_count,
							want.cluster_count);
				end
			end
		end
	end

endmodule
`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the occupancy-grid labeler with points, labelling runs, label reads
// and clears under several region sizes and thresholds, with bursty requests
// and a stalling receiver; the checker beside the block judges every reply.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import gocl_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    pending;
	int                    failures;
	int                    points_binned;
	int                    labelings;
	int                    max_clusters;

	// Burst shaping for the sender
	int burst_left;
	int requests_sent;
	int reads_sent;

	grid_occupancy_component_labeler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	grid_label_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.pending(pending), .failures(failures), .points_binned(points_binned),
		.labelings(labelings), .max_clusters(max_clusters)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stall: switch pattern whenever a random timer runs out, between none,
	// light random, heavy random and long solid stalls
	int stall_mode;
	int stall_timer;
	initial begin
		out_stall   = 1'b0;
		stall_mode  = 0;
		stall_timer = 0;
	end
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  <= $urandom_range(0, 3);
			stall_timer <= $urandom_range(50, 400);
		end else begin
			stall_timer <= stall_timer - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_timer % 32) < 20;
		endcase
	end

	// Hold the request until taken; drop valid only when a gap follows
	task automatic send_request(in_t req);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		if (req.action == ACT_READ)
			reads_sent++;
	endtask

	// Pause until every reply is back, with a margin for work in flight
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_regs(logic [15:0] roi, logic [15:0] thr);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_ROI;
		cfg_data <= roi;
		@(posedge clk);
		cfg_idx  <= CFG_THR;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic in_t mk(action_t a, int px, int py, int cx, int cy);
		in_t r;
		r.action  = a;
		r.point_x = 16'(px);
		r.point_y = 16'(py);
		r.cell_x  = 8'(cx);
		r.cell_y  = 8'(cy);
		return r;
	endfunction

	function automatic in_t random_noise(action_t a);
		return mk(a, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// One phase: clustered points around a few centres, reads and, if n_labels,
	// labelling runs two thirds of the way in (then reads of fresh labels) and last
	task automatic random_phase(int n_items, int roi, int n_labels);
		int cxs [4];
		int cys [4];
		int k, spread;
		for (int i = 0; i < 4; i++) begin
			cxs[i] = int'($urandom_range(0, roi)) - roi / 2;
			cys[i] = int'($urandom_range(0, roi)) - roi / 2;
		end
		spread = roi / 24 + 1;
		for (int i = 0; i < n_items; i++) begin
			k = $urandom_range(0, 99);
			if (n_labels > 0 && (i == n_items * 2 / 3 || i == n_items - 1))
				send_request(mk(ACT_LABEL, $urandom, $urandom, $urandom, $urandom));
			else if (k < 60)
				send_request(mk(ACT_ADD,
					cxs[i%4] + int'($urandom_range(0, 2*spread)) - spread,
					cys[i%4] + int'($urandom_range(0, 2*spread)) - spread,
					$urandom, $urandom));
			else if (k < 70)
				send_request(random_noise(ACT_ADD));
			else if (k < 90)
				send_request(mk(ACT_READ, $urandom, $urandom,
					$urandom_range(0, 127), $urandom_range(0, 127)));
			else
				send_request(random_noise(ACT_READ));
		end
	endtask

	initial begin
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_idx       = CFG_ROI;
		cfg_data      = '0;
		burst_left    = 0;
		requests_sent = 0;
		reads_sent    = 0;
		arst_n        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: region edges, saturation, out-of-range read, relabel, clear
		send_request(mk(ACT_READ, 0, 0, 0, 0));
		send_request(mk(ACT_ADD, -32768, -32768, 0, 0));
		send_request(mk(ACT_ADD, 32767, 32767, 0, 0));
		send_request(mk(ACT_ADD, -2500, -2500, 0, 0));
		send_request(mk(ACT_ADD, 2499, 2499, 0, 0));
		send_request(mk(ACT_ADD, 2500, 0, 0, 0));
		send_request(mk(ACT_ADD, 0, -2501, 0, 0));
		for (int i = 0; i < 17; i++)
			send_request(mk(ACT_ADD, 0, 0, 0, 0));
		send_request(mk(ACT_LABEL, 0, 0, 0, 0));
		send_request(mk(ACT_READ, 0, 0, 64, 64));
		send_request(mk(ACT_READ, 0, 0, 63, 63));
		send_request(mk(ACT_READ, 0, 0, 255, 255));
		send_request(mk(ACT_READ, 0, 0, 128, 5));
		send_request(mk(ACT_CLEAR, 0, 0, 0, 0));
		send_request(mk(ACT_READ, 0, 0, 64, 64));

		// Threshold fifteen with the smallest region: nothing gets occupied
		write_regs(16'd1, 16'd15);
		for (int i = 0; i < 20; i++)
			send_request(mk(ACT_ADD, $urandom_range(0, 1) - 1, 0, 0, 0));
		send_request(mk(ACT_LABEL, 0, 0, 0, 0));
		send_request(mk(ACT_READ, 0, 0, 64, 64));

		// Largest region, lowest threshold
		write_regs(16'd65535, 16'd0);
		random_phase(380, 65535, 1);

		// Random settings, small regions give dense clusters
		for (int p = 0; p < 3; p++) begin
			automatic int r = $urandom_range(128, 4000);
			write_regs(16'(r), 16'($urandom_range(0, 14)));
			if (p == 1)
				send_request(mk(ACT_CLEAR, 0, 0, 0, 0));
			random_phase(p == 2 ? 420 : 380, r, p == 2 ? 0 : 1);
		end
		write_regs(16'd14, 16'd14);
		random_phase(300, 14, 1);

		drain();
		$display("%0d requests (%0d reads), %0d points binned, %0d labelling runs",
			requests_sent, reads_sent, points_binned, labelings);
		$display("largest cluster count seen: %0d", max_clusters);
		if (failures == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/gocl_pkg.sv
rtl/gocl_ctrl.sv
rtl/gocl_datapath.sv
rtl/grid_occupancy_component_labeler.sv
rtl/gocl_checker.sv
dv/grid_label_checker.sv
dv/tb.sv
